@@ rtl/lru_eviction_candidate_pool_core_defines.svh @@
// Assertion macros shared by the eviction candidate pool RTL.
// Included by files that carry concurrent checks; needs no other file.
`ifndef LRU_EVICTION_CANDIDATE_POOL_CORE_DEFINES_SVH
`define LRU_EVICTION_CANDIDATE_POOL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LECP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define LECP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define LECP_ASSERT_NOW(label, clk, rst, ante, cons)
`define LECP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/lecp_pkg.sv @@
// Types and fixed field widths for the eviction candidate pool.
// Used by the channel interfaces, the RAM wrapper users and the top level.
package lecp_pkg;

   localparam int OP_W   = 2;
   localparam int KEY_W  = 32;
   localparam int DB_W   = 4;
   localparam int CLK_W  = 24;
   localparam int OCC_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FULL_CHK,
      ST_UP_CMP,
      ST_DN_CMP,
      ST_PLACE,
      ST_POP,
      ST_RESP
   } state_type;

   // Idle time with wraparound: clock + (max - stamp) equals clock - stamp - 1 mod 2^24.
   function automatic logic [CLK_W-1:0] idle_of(input logic [CLK_W-1:0] clk,
                                                 input logic [CLK_W-1:0] stamp);
      logic [CLK_W-1:0] diff;
      diff = clk - stamp;
      return (clk >= stamp) ? diff : diff - CLK_W'(1);
   endfunction

endpackage

@@ rtl/lecp_req_if.sv @@
// Request channel of the eviction candidate pool: valid/ready plus one command.
// Depends on lecp_pkg for the operation type and field widths.
interface lecp_req_if import lecp_pkg::*; ();
   logic              valid;
   logic              ready;
   op_type            op;
   logic [KEY_W-1:0]  key_handle;
   logic [DB_W-1:0]   db_index;
   logic [CLK_W-1:0]  access_stamp;

   modport source (output valid, op, key_handle, db_index, access_stamp, input ready);
   modport sink   (input valid, op, key_handle, db_index, access_stamp, output ready);
endinterface

@@ rtl/lecp_rsp_if.sv @@
// Response channel of the eviction candidate pool: valid/ready plus one result.
// Depends on lecp_pkg for field widths.
interface lecp_rsp_if import lecp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              inserted;
   logic              popped_valid;
   logic [KEY_W-1:0]  popped_key;
   logic [DB_W-1:0]   popped_db;
   logic [CLK_W-1:0]  popped_idle;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, inserted, popped_valid, popped_key, popped_db,
                   popped_idle, occupancy, input ready);
   modport sink   (input valid, inserted, popped_valid, popped_key, popped_db,
                   popped_idle, occupancy, output ready);
endinterface

@@ rtl/lecp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module lecp_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lru_eviction_candidate_pool_core.sv @@
// Top level of the approximate-LRU eviction candidate pool.
// Depends on lecp_pkg, lecp_req_if, lecp_rsp_if, lecp_ram and the defines header.
//
// Usage:
//   req_chan carries one command per transaction: insert a candidate (key handle,
//   database index, stored LRU stamp), pop the most idle entry, or clear the pool.
//   rsp_chan returns exactly one result per command: inserted flag, popped entry
//   fields and the occupancy after the command. csr_wr_en/csr_wr_data load the
//   24-bit LRU clock used to turn stamps into idle times; write it while idle.
//   The entries live sorted by idle time in one RAM with a single read and write
//   port, so an insert walks the pool one slot per cycle through that port while
//   shifting entries to open a gap.
// Flow: a command is taken in idle and decoded; clear, no-op, pop on empty and
//   insert into empty then go to the result; pop reads the top slot, then responds;
//   other inserts walk the pool in the compare states, after a slot 0 check if full.
//   One command is in work at a time; req_chan.ready is high only while idle, so the
//   next command is taken in the cycle after the result is accepted at the earliest.
// Reset empties the pool and zeroes the clock; the RAM needs no clearing pass.
// While rsp_chan stalls, the result is held and no new command is taken.
`include "lru_eviction_candidate_pool_core_defines.svh"
module lru_eviction_candidate_pool_core import lecp_pkg::*; #(
   parameter int POOL_DEPTH = 16,
   parameter int KEY_BITS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   lecp_req_if.sink          req_chan,
   lecp_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [CLK_W-1:0]  csr_wr_data
);

   localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int ENT_W = CLK_W + KW + DB_W;
   localparam int IW    = $clog2(POOL_DEPTH);
   localparam int CW    = $clog2(POOL_DEPTH + 1);
   localparam int CW1   = CW + 1;
   localparam logic [CW-1:0] FULL_C = CW'(POOL_DEPTH);

   state_type         state_ff, state_in;
   logic [CLK_W-1:0]  clock_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   op_type            op_ff, op_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [DB_W-1:0]   db_ff, db_in;
   logic [CLK_W-1:0]  idle_ff, idle_in;
   logic              ins_ff, ins_in;
   logic              pv_ff, pv_in;
   logic [KW-1:0]     pk_ff, pk_in;
   logic [DB_W-1:0]   pd_ff, pd_in;
   logic [CLK_W-1:0]  pi_ff, pi_in;

   logic              wr_en, rd_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   logic [ENT_W-1:0]  wr_data, rd_data, new_entry;
   logic [CLK_W-1:0]  rd_idle;
   logic [KW-1:0]     rd_key;
   logic [DB_W-1:0]   rd_db;
   logic [CW-1:0]     idx_inc, idx_dec, idx_inc2, idx_dec2, cnt_inc, cnt_dec;
   logic [CW1-1:0]    idx_inc2_wide;
   logic              pool_full;

   assign new_entry = {idle_ff, key_ff, db_ff};
   assign rd_idle   = rd_data[ENT_W-1 -: CLK_W];
   assign rd_key    = rd_data[DB_W +: KW];
   assign rd_db     = rd_data[DB_W-1:0];

   assign idx_inc       = idx_ff + CW'(1);
   assign idx_dec       = idx_ff - CW'(1);
   assign idx_inc2      = idx_ff + CW'(2);
   assign idx_dec2      = idx_ff - CW'(2);
   assign cnt_inc       = count_ff + CW'(1);
   assign cnt_dec       = count_ff - CW'(1);
   assign idx_inc2_wide = CW1'(idx_ff) + CW1'(2);
   assign pool_full     = (count_ff == FULL_C);

   lecp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (POOL_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         clock_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            clock_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      db_ff   <= db_in;
      idle_ff <= idle_in;
      ins_ff  <= ins_in;
      pv_ff   <= pv_in;
      pk_ff   <= pk_in;
      pd_ff   <= pd_in;
      pi_ff   <= pi_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      db_in    = db_ff;
      idle_in  = idle_ff;
      ins_in   = ins_ff;
      pv_in    = pv_ff;
      pk_in    = pk_ff;
      pd_in    = pd_ff;
      pi_in    = pi_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[IW-1:0];
      wr_data  = new_entry;
      rd_en    = 1'b0;
      rd_addr  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.op;
               key_in   = req_chan.key_handle[KW-1:0];
               db_in    = req_chan.db_index;
               idle_in  = idle_of(clock_ff, req_chan.access_stamp);
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ins_in   = 1'b0;
            pv_in    = 1'b0;
            pk_in    = '0;
            pd_in    = '0;
            pi_in    = '0;
            state_in = ST_RESP;
            case (op_ff)
               OP_INSERT: begin
                  if (pool_full) begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_FULL_CHK;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     ins_in   = 1'b1;
                     count_in = cnt_inc;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = cnt_dec[IW-1:0];
                     idx_in   = count_ff;
                     state_in = ST_UP_CMP;
                  end
               end
               OP_POP: begin
                  if (count_ff != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = cnt_dec[IW-1:0];
                     state_in = ST_POP;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_FULL_CHK: begin
            // Slot 0 holds the least idle entry; a newcomer must beat it.
            if (rd_idle >= idle_ff) begin
               state_in = ST_RESP;
            end else begin
               idx_in   = '0;
               rd_en    = 1'b1;
               rd_addr  = IW'(1);
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            // Full pool: slide entries down over the dropped slot 0.
            if (rd_idle <= idle_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_inc;
               if (idx_inc2_wide < CW1'(count_ff)) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_inc2[IW-1:0];
               end else begin
                  state_in = ST_PLACE;
               end
            end else begin
               wr_en    = 1'b1;
               ins_in   = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_UP_CMP: begin
            // Not full: move more idle entries up one slot, ties stay below.
            if (rd_idle > idle_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_dec;
               if (idx_ff > CW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_dec2[IW-1:0];
               end else begin
                  state_in = ST_PLACE;
               end
            end else begin
               wr_en    = 1'b1;
               ins_in   = 1'b1;
               count_in = cnt_inc;
               state_in = ST_RESP;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            ins_in   = 1'b1;
            if (!pool_full) begin
               count_in = cnt_inc;
            end
            state_in = ST_RESP;
         end
         ST_POP: begin
            pv_in    = 1'b1;
            pk_in    = rd_key;
            pd_in    = rd_db;
            pi_in    = rd_idle;
            count_in = cnt_dec;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = (state_ff == ST_RESP);
   assign rsp_chan.inserted     = ins_ff;
   assign rsp_chan.popped_valid = pv_ff;
   assign rsp_chan.popped_key   = KEY_W'(pk_ff);
   assign rsp_chan.popped_db    = pd_ff;
   assign rsp_chan.popped_idle  = pi_ff;
   assign rsp_chan.occupancy    = OCC_W'(count_ff);

   `LECP_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_C)
   `LECP_ASSERT_NOW(a_one_side, clock, reset, rsp_chan.valid, !req_chan.ready)
   `LECP_ASSERT_NEXT(a_pop_shrinks, clock, reset, state_ff == ST_POP, count_ff + CW'(1) == $past(count_ff))
   `LECP_ASSERT_NOW(a_wr_in_range, clock, reset, wr_en, CW'(wr_addr) <= count_ff && CW'(wr_addr) < FULL_C)
   `LECP_ASSERT_NEXT(a_pop_flag, clock, reset, state_ff == ST_POP, rsp_chan.valid && rsp_chan.popped_valid)

endmodule
